// ===== rtl/hpst_pkg.sv =====
`timescale 1ns / 1ps

package hpst_pkg;

  localparam int COORD_BITS = 32;
  localparam int COEF_BITS  = 32;
  localparam int FRAC_SHIFT = 30;
  localparam int DIGIT_BITS = 32;
  localparam int MUL_STAGES = 3;
  localparam int NUM_STAGES = 2 * MUL_STAGES + 5;

  localparam logic signed [COEF_BITS-1:0] ONE_Q30 = COEF_BITS'(1) << FRAC_SHIFT;

  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

// ===== rtl/hpst_in_if.sv =====
`timescale 1ns / 1ps

interface hpst_in_if #(
  parameter int COORD_BITS = hpst_pkg::COORD_BITS
) ();
  logic                                  valid;
  logic                                  ready;
  logic signed [hpst_pkg::COEF_BITS-1:0] edge_a;
  logic signed [hpst_pkg::COEF_BITS-1:0] edge_b;
  logic signed [COORD_BITS-1:0]          edge_c;
  logic signed [COORD_BITS-1:0]          top_x;
  logic signed [COORD_BITS-1:0]          top_y;
  logic signed [COORD_BITS-1:0]          bottom_x;
  logic                                  halfedge_side;
  logic signed [COORD_BITS-1:0]          point_x;
  logic signed [COORD_BITS-1:0]          point_y;

  modport source (
    output valid, edge_a, edge_b, edge_c, top_x, top_y, bottom_x, halfedge_side,
           point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, edge_a, edge_b, edge_c, top_x, top_y, bottom_x, halfedge_side,
           point_x, point_y,
    output ready
  );
endinterface

// ===== rtl/hpst_out_if.sv =====
`timescale 1ns / 1ps

interface hpst_out_if ();
  logic valid;
  logic ready;
  logic point_is_right;

  modport source (output valid, point_is_right, input ready);
  modport sink (input valid, point_is_right, output ready);
endinterface

// ===== rtl/hpst_mul.sv =====
`timescale 1ns / 1ps

module hpst_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                            clk,
  input  logic [hpst_pkg::MUL_STAGES-1:0] adv,
  input  logic signed [WA-1:0]            a,
  input  logic signed [WB-1:0]            b,
  output logic signed [WA+WB-1:0]         p
);

  localparam int D   = hpst_pkg::DIGIT_BITS;
  localparam int NA  = (WA + D - 1) / D;
  localparam int NB  = (WB + D - 1) / D;
  localparam int EA  = NA * D;
  localparam int EB  = NB * D;
  localparam int PPW = 2 * D + 2;
  localparam int RW  = D * (NB + 1) + 4;
  localparam int SW  = D * (NA + NB + 1) + 4;

  logic signed [EA-1:0]  ax;
  logic signed [EB-1:0]  bx;
  logic signed [D:0]     da [NA];
  logic signed [D:0]     db [NB];
  logic signed [PPW-1:0] pp [NA][NB];
  logic signed [RW-1:0]  row_sum [NA];
  logic signed [RW-1:0]  row [NA];
  logic signed [SW-1:0]  total;

  assign ax = EA'(a);
  assign bx = EB'(b);

  // top digit carries the sign, lower digits are unsigned
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        da[i] = {ax[EA-1], ax[i*D +: D]};
      end else begin
        da[i] = {1'b0, ax[i*D +: D]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        db[j] = {bx[EB-1], bx[j*D +: D]};
      end else begin
        db[j] = {1'b0, bx[j*D +: D]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= da[i] * db[j];
        end
      end
    end
  end

  always_comb begin
    logic signed [RW-1:0] acc;
    for (int i = 0; i < NA; i++) begin
      acc = '0;
      for (int j = 0; j < NB; j++) begin
        acc = acc + (RW'(pp[i][j]) <<< (D * j));
      end
      row_sum[i] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      row <= row_sum;
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + (SW'(row[i]) <<< (D * i));
    end
    total = acc;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      p <= total[WA+WB-1:0];
    end
  end

endmodule

// ===== rtl/hpst_ctrl.sv =====
`timescale 1ns / 1ps

module hpst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_ready,
  output hpst_pkg::pipe_ctrl_t ctl
);

  localparam int N = hpst_pkg::NUM_STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] adv;

  // a stage moves when the output drains or some stage at or after it is empty
  always_comb begin
    for (int s = 0; s < N; s++) begin
      adv[s] = out_ready || !(&(valid | ((N'(1) << s) - N'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < N; s++) begin
        if (adv[s]) begin
          valid[s] <= (s == 0) ? in_valid : valid[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  assign ctl.adv   = adv;
  assign ctl.valid = valid;

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(valid) == $past($countones(valid)) + $past(in_valid && adv[0])
                                  - $past(valid[N-1] && out_ready))
    else $error("pipeline item count does not match accepted and delivered items");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&valid) && !out_ready |-> !adv[0])
    else $error("item accepted into a full stalled pipeline");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    valid == '0 |-> adv[0])
    else $error("empty pipeline refuses an item");

  a_drain_all: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> &adv)
    else $error("stage held while output drains");
`endif

endmodule

// ===== rtl/halfedge_point_side_test_core.sv =====
//  channel  modport  payload                                        moves on
//  query    sink     edge_a edge_b edge_c top_x top_y bottom_x      valid && ready
//                    halfedge_side point_x point_y
//  answer   source   point_is_right                                 valid && ready
//
//  One item per cycle sustained while answers are taken; the pipe is two three-stage
//  multiplier arrays in series plus input, difference, pre-add, sum and decide stages.
//  Reset clears only the stage valid bits.
//  A full stage holds while the stage after it holds; empty stages keep filling,
//  so bubbles close up under an answer stall.
`timescale 1ns / 1ps

module halfedge_point_side_test_core #(
  parameter int COORD_BITS = hpst_pkg::COORD_BITS
) (
  input logic        clk,
  input logic        rst,
  hpst_in_if.sink    query,
  hpst_out_if.source answer
);

  localparam int W    = COORD_BITS;
  localparam int CB   = hpst_pkg::COEF_BITS;
  localparam int FS   = hpst_pkg::FRAC_SHIFT;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * DW;
  localparam int DFW  = PW + 1;
  localparam int KW   = 2 * CB + 1;
  localparam int CMPW = CB + DW + 1;
  localparam int TW   = CB + DW + 1;
  localparam int FW   = 2 * TW + 2;

  localparam int S_IN   = 0;
  localparam int S_DIFF = 1;
  localparam int S_M1   = 2;
  localparam int S_PRE  = S_M1 + hpst_pkg::MUL_STAGES;
  localparam int S_M2   = S_PRE + 1;
  localparam int S_SUM  = S_M2 + hpst_pkg::MUL_STAGES;
  localparam int S_OUT  = S_SUM + 1;

  localparam logic signed [KW-1:0] K_BIAS = KW'(1) << (2 * FS);

  typedef struct packed {
    logic ros;
    logic side;
    logic a_one;
    logic bneg;
  } flag_t;

  typedef struct packed {
    logic [DW-1:0] dyp;
    logic [DW-1:0] cpx;
    logic [DW-1:0] pc;
    logic [DW-1:0] ct;
    logic [CB-1:0] b;
    flag_t         f;
  } carry1_t;

  typedef struct packed {
    flag_t f;
    logic  above_slope;
    logic  above_line;
  } dec_t;

  typedef struct packed {
    logic [PW-1:0] dxp2;
    logic [PW-1:0] dxdy;
    dec_t          d;
  } carry2_t;

  hpst_pkg::pipe_ctrl_t ctl;

  logic signed [CB-1:0] a0, b0;
  logic signed [W-1:0]  c0, tx0, ty0, bx0, px0, py0;
  logic                 side0;

  logic signed [CB-1:0] a1, b1;
  logic signed [W-1:0]  px1, py1;
  logic signed [DW-1:0] dxp1, dxs1;
  carry1_t              cy1 [4];
  carry1_t              cy1_next;

  logic signed [CB+DW-1:0] bdxp_p;
  logic signed [W+CB-1:0]  pyb_p;
  logic signed [PW-1:0]    dxp2_p, dyp2_p, dxdy_p, dxsdy_p;
  logic signed [2*CB-1:0]  bb_p;
  logic signed [CB+W-1:0]  apx_p;

  logic signed [CB-1:0]  b5;
  logic signed [DFW-1:0] diff5;
  logic signed [KW-1:0]  k5;
  logic signed [PW-1:0]  dxsdy5;
  logic signed [TW-1:0]  t1_5, t3_5;
  carry2_t               cy2 [4];
  carry2_t               cy2_next;

  logic signed [CB+DFW-1:0] lhs_p;
  logic signed [PW+KW-1:0]  rhs_p;
  logic signed [2*TW-1:0]   t1sq_p, t3sq_p;

  logic signed [FW-1:0] lhs9, rhs9, t1sq9, sq2_9;
  dec_t                 d9;

  logic above;
  logic result;
  logic res10;

  hpst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .out_ready (answer.ready),
    .ctl       (ctl)
  );

  assign query.ready          = ctl.adv[S_IN];
  assign answer.valid         = ctl.valid[S_OUT];
  assign answer.point_is_right = res10;

  always_ff @(posedge clk) begin
    if (ctl.adv[S_IN]) begin
      a0    <= query.edge_a;
      b0    <= query.edge_b;
      c0    <= query.edge_c;
      tx0   <= query.top_x;
      ty0   <= query.top_y;
      bx0   <= query.bottom_x;
      side0 <= query.halfedge_side;
      px0   <= query.point_x;
      py0   <= query.point_y;
    end
  end

  always_comb begin
    cy1_next.dyp     = DW'(py0) - DW'(ty0);
    cy1_next.cpx     = DW'(c0) - DW'(px0);
    cy1_next.pc      = DW'(py0) - DW'(c0);
    cy1_next.ct      = DW'(c0) - DW'(ty0);
    cy1_next.b       = b0;
    cy1_next.f.ros   = px0 > tx0;
    cy1_next.f.side  = side0;
    cy1_next.f.a_one = a0 == hpst_pkg::ONE_Q30;
    cy1_next.f.bneg  = b0[CB-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[S_DIFF]) begin
      a1     <= a0;
      b1     <= b0;
      px1    <= px0;
      py1    <= py0;
      dxp1   <= DW'(px0) - DW'(tx0);
      dxs1   <= DW'(tx0) - DW'(bx0);
      cy1[0] <= cy1_next;
    end
    for (int k = 1; k < 4; k++) begin
      if (ctl.adv[S_DIFF+k]) begin
        cy1[k] <= cy1[k-1];
      end
    end
  end

  hpst_mul #(.WA(CB), .WB(DW)) u_m_bdxp (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(b1), .b(dxp1), .p(bdxp_p)
  );
  hpst_mul #(.WA(W), .WB(CB)) u_m_pyb (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(py1), .b(b1), .p(pyb_p)
  );
  hpst_mul #(.WA(DW), .WB(DW)) u_m_dxp2 (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(dxp1), .b(dxp1), .p(dxp2_p)
  );
  hpst_mul #(.WA(DW), .WB(DW)) u_m_dyp2 (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a($signed(cy1[0].dyp)),
    .b($signed(cy1[0].dyp)), .p(dyp2_p)
  );
  hpst_mul #(.WA(DW), .WB(DW)) u_m_dxdy (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(dxp1), .b($signed(cy1[0].dyp)),
    .p(dxdy_p)
  );
  hpst_mul #(.WA(DW), .WB(DW)) u_m_dxsdy (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(dxs1), .b($signed(cy1[0].dyp)),
    .p(dxsdy_p)
  );
  hpst_mul #(.WA(CB), .WB(CB)) u_m_bb (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(b1), .b(b1), .p(bb_p)
  );
  hpst_mul #(.WA(CB), .WB(W)) u_m_apx (
    .clk(clk), .adv(ctl.adv[S_M1+2:S_M1]), .a(a1), .b(px1), .p(apx_p)
  );

  always_comb begin
    cy2_next.dxp2          = dxp2_p;
    cy2_next.dxdy          = dxdy_p;
    cy2_next.d.f           = cy1[3].f;
    cy2_next.d.above_slope = (CMPW'($signed(cy1[3].dyp)) <<< FS) >= CMPW'(bdxp_p);
    cy2_next.d.above_line  = CMPW'(pyb_p) > (CMPW'($signed(cy1[3].cpx)) <<< FS);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[S_PRE]) begin
      b5     <= $signed(cy1[3].b);
      diff5  <= DFW'(dxp2_p) - DFW'(dyp2_p);
      k5     <= KW'(bb_p) + K_BIAS;
      dxsdy5 <= dxsdy_p;
      t1_5   <= (TW'($signed(cy1[3].pc)) <<< FS) + TW'(apx_p);
      t3_5   <= (TW'($signed(cy1[3].ct)) <<< FS) - TW'(apx_p);
      cy2[0] <= cy2_next;
    end
    for (int k = 1; k < 4; k++) begin
      if (ctl.adv[S_PRE+k]) begin
        cy2[k] <= cy2[k-1];
      end
    end
  end

  hpst_mul #(.WA(CB), .WB(DFW)) u_m_lhs (
    .clk(clk), .adv(ctl.adv[S_M2+2:S_M2]), .a(b5), .b(diff5), .p(lhs_p)
  );
  hpst_mul #(.WA(PW), .WB(KW)) u_m_rhs (
    .clk(clk), .adv(ctl.adv[S_M2+2:S_M2]), .a(dxsdy5), .b(k5), .p(rhs_p)
  );
  hpst_mul #(.WA(TW), .WB(TW)) u_m_t1sq (
    .clk(clk), .adv(ctl.adv[S_M2+2:S_M2]), .a(t1_5), .b(t1_5), .p(t1sq_p)
  );
  hpst_mul #(.WA(TW), .WB(TW)) u_m_t3sq (
    .clk(clk), .adv(ctl.adv[S_M2+2:S_M2]), .a(t3_5), .b(t3_5), .p(t3sq_p)
  );

  always_ff @(posedge clk) begin
    if (ctl.adv[S_SUM]) begin
      lhs9  <= FW'(lhs_p) <<< FS;
      rhs9  <= FW'(rhs_p) + (FW'($signed(cy2[3].dxdy)) <<< (2 * FS + 1));
      t1sq9 <= FW'(t1sq_p);
      sq2_9 <= (FW'($signed(cy2[3].dxp2)) <<< (2 * FS)) + FW'(t3sq_p);
      d9    <= cy2[3].d;
    end
  end

  always_comb begin
    logic par;
    logic far_above;
    par       = (lhs9 < rhs9) ^ d9.f.bneg;
    far_above = t1sq9 > sq2_9;
    if (!d9.f.a_one) begin
      above = far_above;
    end else if (d9.f.ros ^ d9.f.bneg) begin
      above = d9.above_slope ? 1'b1 : par;
    end else begin
      above = (d9.above_line ^ d9.f.bneg) ? par : 1'b0;
    end
    if (d9.f.ros ^ d9.f.side) begin
      result = d9.f.ros;
    end else begin
      result = d9.f.side ? !above : above;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[S_OUT]) begin
      res10 <= result;
    end
  end

endmodule

// ===== dv/tb_halfedge_point_side_test_core.sv =====
`timescale 1ns / 1ps

module tb_halfedge_point_side_test_core;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [hpst_pkg::COEF_BITS-1:0]  edge_a;
    logic signed [hpst_pkg::COEF_BITS-1:0]  edge_b;
    logic signed [hpst_pkg::COORD_BITS-1:0] edge_c;
    logic signed [hpst_pkg::COORD_BITS-1:0] top_x;
    logic signed [hpst_pkg::COORD_BITS-1:0] top_y;
    logic signed [hpst_pkg::COORD_BITS-1:0] bottom_x;
    logic                                   halfedge_side;
    logic signed [hpst_pkg::COORD_BITS-1:0] point_x;
    logic signed [hpst_pkg::COORD_BITS-1:0] point_y;
  } query_t;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  localparam logic signed [31:0] ONE_Q30     = hpst_pkg::ONE_Q30;
  localparam logic signed [31:0] Q_ONE       = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX       = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] HALF_Q30    = 32'sh2000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;

  localparam int IDLE_PCT      = 23;
  localparam int RANDOM_ITEMS  = 400;
  localparam int DRAIN_CYCLES  = 16;
  localparam int TIMEOUT_NS    = 400_000;

  class side_scoreboard;
    bit sides_due[$];
    int fail_count;
    int answers_seen;

    function bit predict_right_of(query_t q);
      wide_t a, b, c, tx, ty, bx, px, py;
      wide_t dxp, dyp, dxs, lhs, rhs, k, yl, t1, t2, t3;
      bit ros, bneg, fast, above;
      a  = $signed(q.edge_a);
      b  = $signed(q.edge_b);
      c  = $signed(q.edge_c);
      tx = $signed(q.top_x);
      ty = $signed(q.top_y);
      bx = $signed(q.bottom_x);
      px = $signed(q.point_x);
      py = $signed(q.point_y);
      ros = px > tx;
      if (ros && q.halfedge_side == SIDE_LEFT) return 1'b1;
      if (!ros && q.halfedge_side == SIDE_RIGHT) return 1'b0;
      if (a == (wide_t'(1) <<< 30)) begin
        dxp  = px - tx;
        dyp  = py - ty;
        bneg = b < 0;
        fast = 1'b0;
        if (ros != bneg) begin
          above = (dyp <<< 30) >= b * dxp;
          fast  = above;
        end else begin
          lhs   = (px <<< 30) + py * b;
          above = lhs > (c <<< 30);
          if (bneg) above = !above;
          if (!above) fast = 1'b1;
        end
        if (!fast) begin
          dxs   = tx - bx;
          lhs   = (b * (dxp * dxp - dyp * dyp)) <<< 30;
          k     = (wide_t'(1) <<< 60) + b * b;
          rhs   = dxs * dyp * k + ((dxp * dyp) <<< 61);
          above = lhs < rhs;
          if (bneg) above = !above;
        end
      end else begin
        yl    = (c <<< 30) - a * px;
        t1    = (py <<< 30) - yl;
        t2    = (px - tx) <<< 30;
        t3    = yl - (ty <<< 30);
        above = t1 * t1 > t2 * t2 + t3 * t3;
      end
      return (q.halfedge_side == SIDE_LEFT) ? above : !above;
    endfunction

    function void note(query_t q);
      sides_due.push_back(predict_right_of(q));
    endfunction

    function int pending();
      return sides_due.size();
    endfunction

    task report_mismatch(string what);
      fail_count++;
      $display("mismatch at answer %0d: %s", answers_seen, what);
    endtask

    task check(logic got);
      logic want;
      if (sides_due.size() == 0) begin
        report_mismatch($sformatf("point_is_right=%b with no query pending", got));
      end else begin
        want = sides_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf("point_is_right got %b want %b", got, want));
      end
      answers_seen++;
    endtask
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_idle_pct;
  side_scoreboard sb;

  hpst_in_if  query ();
  hpst_out_if answer ();

  halfedge_point_side_test_core dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .answer (answer)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) answer.ready <= 1'b0;
    else answer.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && answer.valid && answer.ready) sb.check(answer.point_is_right);
  end

  function automatic query_t mk(logic signed [31:0] a, logic signed [31:0] b,
                                logic signed [31:0] c, logic signed [31:0] tx,
                                logic signed [31:0] ty, logic signed [31:0] bx,
                                logic side, logic signed [31:0] px,
                                logic signed [31:0] py);
    query_t q;
    q.edge_a        = a;
    q.edge_b        = b;
    q.edge_c        = c;
    q.top_x         = tx;
    q.top_y         = ty;
    q.bottom_x      = bx;
    q.halfedge_side = side;
    q.point_x       = px;
    q.point_y       = py;
    return q;
  endfunction

  function automatic logic signed [31:0] rand_coord(bit full_range);
    int whole;
    int frac;
    if (full_range) return $urandom;
    whole = int'($urandom_range(32)) - 16;
    frac  = $urandom_range(1) ? int'($urandom_range(65535)) : 0;
    return (whole <<< 16) + frac;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     pick;
    bit     full_range;
    longint t;
    full_range = ($urandom_range(99) < 35);
    pick = $urandom_range(99);
    if (pick < 55) q.edge_a = ONE_Q30;
    else if (pick < 70) q.edge_a = $urandom_range(32'h8000_0000) - 32'h4000_0000;
    else if (pick < 85) q.edge_a = $urandom;
    else begin
      case ($urandom_range(3))
        0: q.edge_a = '0;
        1: q.edge_a = NEG_ONE_Q30;
        2: q.edge_a = ONE_Q30 - 1;
        default: q.edge_a = ONE_Q30 + 1;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 60) q.edge_b = $urandom_range(32'h8000_0000) - 32'h4000_0000;
    else if (pick < 80) q.edge_b = $urandom;
    else begin
      case ($urandom_range(3))
        0: q.edge_b = '0;
        1: q.edge_b = ONE_Q30;
        2: q.edge_b = NEG_ONE_Q30;
        default: q.edge_b = Q_MIN;
      endcase
    end
    q.edge_c        = rand_coord(full_range);
    q.top_x         = rand_coord(full_range);
    q.top_y         = rand_coord(full_range);
    q.bottom_x      = rand_coord(full_range);
    q.point_x       = rand_coord(full_range);
    q.point_y       = rand_coord(full_range);
    q.halfedge_side = $urandom_range(1);
    if ($urandom_range(9) == 0) q.bottom_x = q.top_x;
    pick = $urandom_range(9);
    if (pick == 0) begin
      q.point_x = q.top_x;
    end else if (pick < 3) begin
      if (q.edge_a == ONE_Q30) begin
        t = longint'($signed(q.edge_c))
            - ((longint'($signed(q.edge_b)) * longint'($signed(q.point_y))) >>> 30);
        q.point_x = t[31:0];
      end else begin
        t = longint'($signed(q.edge_c))
            - ((longint'($signed(q.edge_a)) * longint'($signed(q.point_x))) >>> 30);
        q.point_y = t[31:0];
      end
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      query.valid <= 1'b0;
      @(posedge clk);
    end
    query.valid         <= 1'b1;
    query.edge_a        <= q.edge_a;
    query.edge_b        <= q.edge_b;
    query.edge_c        <= q.edge_c;
    query.top_x         <= q.top_x;
    query.top_y         <= q.top_y;
    query.bottom_x      <= q.bottom_x;
    query.halfedge_side <= q.halfedge_side;
    query.point_x       <= q.point_x;
    query.point_y       <= q.point_y;
    @(posedge clk);
    while (!query.ready) @(posedge clk);
    sb.note(q);
  endtask

  task automatic drain_answers();
    query.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    query_t directed[$];
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    src_idle_pct = IDLE_PCT;
    snk_idle_pct = IDLE_PCT;
    query.valid = 1'b0;
    query.edge_a = '0;
    query.edge_b = '0;
    query.edge_c = '0;
    query.top_x = '0;
    query.top_y = '0;
    query.bottom_x = '0;
    query.halfedge_side = 1'b0;
    query.point_x = '0;
    query.point_y = '0;
    answer.ready = 1'b0;

    directed.push_back(mk(ONE_Q30, 0, 0, 0, 0, -Q_ONE, SIDE_LEFT, Q_ONE, 0));
    directed.push_back(mk(ONE_Q30, 0, 0, 0, 0, -Q_ONE, SIDE_RIGHT, 0, 0));
    directed.push_back(mk(ONE_Q30, HALF_Q30, 0, 0, 0, -Q_ONE, SIDE_RIGHT, Q_ONE, 2 * Q_ONE));
    directed.push_back(mk(ONE_Q30, -HALF_Q30, 0, 0, 0, -Q_ONE, SIDE_LEFT, -Q_ONE, 2 * Q_ONE));
    directed.push_back(mk(ONE_Q30, HALF_Q30, 0, 0, 0, -Q_ONE, SIDE_LEFT, -Q_ONE, 4 * Q_ONE));
    directed.push_back(mk(ONE_Q30, -HALF_Q30, 2 * Q_ONE, 0, 0, -Q_ONE, SIDE_RIGHT, Q_ONE, 0));
    directed.push_back(mk(ONE_Q30, HALF_Q30, 0, 3 * Q_ONE, Q_ONE, 3 * Q_ONE, SIDE_LEFT,
                          -Q_ONE, 4 * Q_ONE));
    directed.push_back(mk(ONE_Q30, -HALF_Q30, 0, 0, Q_ONE, 0, SIDE_RIGHT, Q_ONE, 0));
    directed.push_back(mk(ONE_Q30, 0, Q_ONE, 0, 0, -Q_ONE, SIDE_LEFT, -Q_ONE, -Q_ONE));
    directed.push_back(mk(ONE_Q30, ONE_Q30, 0, Q_ONE, Q_ONE, 0, SIDE_RIGHT,
                          2 * Q_ONE, 2 * Q_ONE));
    directed.push_back(mk(0, Q_MIN, Q_ONE, 0, Q_ONE, -Q_ONE, SIDE_LEFT, -2 * Q_ONE,
                          3 * Q_ONE));
    directed.push_back(mk(NEG_ONE_Q30, Q_MAX, -Q_ONE, Q_ONE, 0, 0, SIDE_RIGHT, 2 * Q_ONE,
                          -Q_ONE));
    directed.push_back(mk(ONE_Q30 - 1, ONE_Q30, 0, 0, 0, 0, SIDE_LEFT, -Q_ONE, Q_ONE));
    directed.push_back(mk(ONE_Q30 + 1, -HALF_Q30, Q_ONE, 0, 0, 0, SIDE_RIGHT, Q_ONE,
                          -Q_ONE));
    directed.push_back(mk(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, SIDE_LEFT, Q_MAX, Q_MAX));
    directed.push_back(mk(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, SIDE_RIGHT, Q_MAX, Q_MIN));
    directed.push_back(mk(ONE_Q30, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, SIDE_LEFT, Q_MIN, Q_MIN));
    directed.push_back(mk(ONE_Q30, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, SIDE_RIGHT,
                          Q_MAX, Q_MAX));
    directed.push_back(mk(ONE_Q30, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, SIDE_LEFT,
                          Q_MIN, Q_MAX));
    directed.push_back(mk(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, SIDE_LEFT, Q_MIN, Q_MIN));
    directed.push_back(mk(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, SIDE_RIGHT, Q_MAX, Q_MAX));
    directed.push_back(mk(0, 0, 0, 0, 0, 0, SIDE_LEFT, 0, 0));
    directed.push_back(mk(-1, -1, -1, -1, -1, -1, SIDE_RIGHT, 0, -1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_query(directed[i]);
    drain_answers();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (n == 250) begin
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
      end
      if (n == 320) drain_answers();
      send_query(random_query());
    end

    drain_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hpst_pkg.sv
rtl/hpst_in_if.sv
rtl/hpst_out_if.sv
rtl/hpst_mul.sv
rtl/hpst_ctrl.sv
rtl/halfedge_point_side_test_core.sv
dv/tb_halfedge_point_side_test_core.sv
